// ===== design/sparse_ternary_weight_sampler_assert.svh =====
// ----------------------------------------------------------------------------
// Sparse ternary weight sampler assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_TERNARY_WEIGHT_SAMPLER_ASSERT_SVH
`define SPARSE_TERNARY_WEIGHT_SAMPLER_ASSERT_SVH

// same-cycle implication
`define STWS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STWS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/stws_pkg.sv =====
// ----------------------------------------------------------------------------
// stws_pkg
// Shared constants, register codes and types of the sparse ternary sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stws_pkg;

	localparam int VECTOR_LENGTH_DEF = 512;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam int MOD_W    = 8;
	localparam int WEIGHT_W = 10;

	localparam logic [1:0] REG_MODULUS    = 2'd0;
	localparam logic [1:0] REG_WEIGHT_MIN = 2'd1;
	localparam logic [1:0] REG_WEIGHT_MAX = 2'd2;

	localparam logic [MOD_W-1:0]    MODULUS_RST    = 8'd251;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MIN_RST = 10'd110;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX_RST = 10'd146;
	localparam logic [WEIGHT_W-1:0] WEIGHT_CAP     = 10'd1023;

	typedef struct packed {
		logic [MOD_W-1:0]    modulus;
		logic [WEIGHT_W-1:0] weight_min;
		logic [WEIGHT_W-1:0] weight_max;
	} cfg_t;

endpackage

`default_nettype wire

// ===== design/stws_coeff_map.sv =====
// ----------------------------------------------------------------------------
// stws_coeff_map
// Maps both nibbles of a random byte to ternary coefficients and counts the
// nonzero ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stws_coeff_map
	import stws_pkg::*;
(
	input  wire logic [7:0]       random_byte,
	input  wire logic [MOD_W-1:0] modulus,
	output logic [MOD_W-1:0]      coeff_first,
	output logic [MOD_W-1:0]      coeff_second,
	output logic [1:0]            nonzero_count
);

	localparam logic [2:0] LOW3_NEG_ONE = 3'd0;
	localparam logic [2:0] LOW3_ONE     = 3'd1;

	function automatic logic [MOD_W-1:0] map_nibble(input logic [3:0] nib,
	                                                input logic [MOD_W-1:0] q);
		logic [MOD_W-1:0] c;
		case (nib[2:0])
			LOW3_NEG_ONE: c = q - MOD_W'(1);
			LOW3_ONE:     c = MOD_W'(1);
			default:      c = '0;
		endcase
		return c;
	endfunction

	assign coeff_first  = map_nibble(random_byte[3:0], modulus);
	assign coeff_second = map_nibble(random_byte[7:4], modulus);

	// a q of one makes the minus-one code zero, so count by value
	assign nonzero_count = {1'b0, (coeff_first != '0)} + {1'b0, (coeff_second != '0)};

endmodule

`default_nettype wire

// ===== design/stws_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// stws_cfg_regs
// APB register file holding the modulus and the accepted weight bounds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stws_cfg_regs
	import stws_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[APB_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.modulus    <= MODULUS_RST;
			cfg_q.weight_min <= WEIGHT_MIN_RST;
			cfg_q.weight_max <= WEIGHT_MAX_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MODULUS:    cfg_q.modulus    <= pwdata[MOD_W-1:0];
				REG_WEIGHT_MIN: cfg_q.weight_min <= pwdata[WEIGHT_W-1:0];
				REG_WEIGHT_MAX: cfg_q.weight_max <= pwdata[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MODULUS:    prdata = APB_DATA_W'(cfg_q.modulus);
			REG_WEIGHT_MIN: prdata = APB_DATA_W'(cfg_q.weight_min);
			REG_WEIGHT_MAX: prdata = APB_DATA_W'(cfg_q.weight_max);
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== design/stws_pipe.sv =====
// ----------------------------------------------------------------------------
// stws_pipe
// Input register, coefficient mapping, batch counters and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stws_pipe
	import stws_pkg::*;
#(
	parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cfg_t                cfg,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [7:0]          random_byte,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [MOD_W-1:0]         coeff_first,
	output logic [MOD_W-1:0]         coeff_second,
	output logic [7:0]               pair_position,
	output logic                     batch_done,
	output logic                     batch_accepted,
	output logic [WEIGHT_W-1:0]      batch_weight
);

	localparam int PAIRS = VECTOR_LENGTH / 2;
	localparam int CNT_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam logic [CNT_W-1:0] LAST_PAIR = CNT_W'(PAIRS - 1);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                out_valid_q;
	logic [CNT_W-1:0]    pair_cnt_q;
	logic [WEIGHT_W-1:0] weight_sum_q;

	logic [MOD_W-1:0]    c0;
	logic [MOD_W-1:0]    c1;
	logic [1:0]          nz;
	logic                advance;
	logic                load;
	logic [WEIGHT_W:0]   w_raw;
	logic [WEIGHT_W-1:0] w_sat;
	logic                done;
	logic                accepted;
	logic [CNT_W+7:0]    pos_ext;

	stws_coeff_map u_map (
		.random_byte   (byte_s1),
		.modulus       (cfg.modulus),
		.coeff_first   (c0),
		.coeff_second  (c1),
		.nonzero_count (nz)
	);

	// result register free or draining this cycle
	assign advance  = !out_valid_q || !out_stall;
	assign load     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign w_raw    = {1'b0, weight_sum_q} + (WEIGHT_W + 1)'(nz);
	assign w_sat    = (w_raw > {1'b0, WEIGHT_CAP}) ? WEIGHT_CAP : w_raw[WEIGHT_W-1:0];
	assign done     = (pair_cnt_q == LAST_PAIR);
	assign accepted = done && (w_sat >= cfg.weight_min) && (w_sat <= cfg.weight_max);
	assign pos_ext  = {8'd0, pair_cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= random_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pair_cnt_q   <= '0;
			weight_sum_q <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (load) begin
				// clear the counters at the end of a vector
				if (done) begin
					pair_cnt_q   <= '0;
					weight_sum_q <= '0;
				end else begin
					pair_cnt_q   <= pair_cnt_q + CNT_W'(1);
					weight_sum_q <= w_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			coeff_first    <= c0;
			coeff_second   <= c1;
			pair_position  <= pos_ext[7:0];
			batch_done     <= done;
			batch_accepted <= accepted;
			batch_weight   <= w_sat;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== design/sparse_ternary_weight_sampler.sv =====
// Pipeline: a byte transfer loads the input register, and the result register takes
// it from there once free or draining; a result is held while out_stall is high.
// Throughput: one byte per cycle unless stalled, set by the single mapping and counting stage.
// Reset: arst_n clears the pipeline valids, pair counter and running weight,
// and loads modulus 251 and weight bounds 110 to 146.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_ternary_weight_sampler
// Turns a stream of random bytes into ternary coefficient pairs, tracks the
// vector weight and flags accepted batches.
// ----------------------------------------------------------------------------

module sparse_ternary_weight_sampler
	import stws_pkg::*;
#(
	parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            random_byte,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [MOD_W-1:0]           coeff_first,
	output logic [MOD_W-1:0]           coeff_second,
	output logic [7:0]                 pair_position,
	output logic                       batch_done,
	output logic                       batch_accepted,
	output logic [WEIGHT_W-1:0]        batch_weight
);

	cfg_t cfg;

	stws_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	stws_pipe #(
		.VECTOR_LENGTH (VECTOR_LENGTH)
	) u_pipe (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.random_byte    (random_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.coeff_first    (coeff_first),
		.coeff_second   (coeff_second),
		.pair_position  (pair_position),
		.batch_done     (batch_done),
		.batch_accepted (batch_accepted),
		.batch_weight   (batch_weight)
	);

endmodule

`default_nettype wire

// ===== design/stws_checker.sv =====
// ----------------------------------------------------------------------------
// stws_checker
// Port-level assertions for the sparse ternary weight sampler, bound to the
// top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_ternary_weight_sampler_assert.svh"

module stws_checker
	import stws_pkg::*;
#(
	parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire logic [MOD_W-1:0]    coeff_first,
	input wire logic [MOD_W-1:0]    coeff_second,
	input wire logic [7:0]          pair_position,
	input wire logic                batch_done,
	input wire logic                batch_accepted,
	input wire logic [WEIGHT_W-1:0] batch_weight
);

	localparam int PAIRS = VECTOR_LENGTH / 2;
	localparam logic [7:0] LAST_POS = 8'((PAIRS - 1) % 256);

	`STWS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({coeff_first, coeff_second, pair_position, batch_done, batch_accepted, batch_weight}), "stalled result changed")

	`STWS_ASSERT_NOW(a_accept_needs_done, out_valid && !batch_done, !batch_accepted, "batch accepted before its last pair")

	`STWS_ASSERT_NOW(a_done_position, out_valid && batch_done, pair_position == LAST_POS, "batch done at the wrong pair position")

	`STWS_ASSERT_NOW(a_empty_takes_input, !out_valid, !in_stall, "input stalled while the result register is empty")

endmodule

bind sparse_ternary_weight_sampler stws_checker #(
	.VECTOR_LENGTH (VECTOR_LENGTH)
) u_stws_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.coeff_first    (coeff_first),
	.coeff_second   (coeff_second),
	.pair_position  (pair_position),
	.batch_done     (batch_done),
	.batch_accepted (batch_accepted),
	.batch_weight   (batch_weight)
);

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: sparse ternary weight sampler regression
// A short scripted run hits the nibble codes and modulus corners, then random
// phases change modulus and weight bounds and stream biased bytes through the
// block. Every result transfer is checked field by field against the script's pair
// or an in-bench model, with random idles on both sides and one long hold-off.
// ----------------------------------------------------------------------------

module tb;
	import stws_pkg::*;

	localparam int VEC_LEN     = VECTOR_LENGTH_DEF;
	localparam int PAIRS       = VEC_LEN / 2;
	localparam int BYTE_GOAL   = 1900;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 31;
	localparam int HOLD_CYCLES = 96;
	localparam int QUIET_LO    = 900;
	localparam int QUIET_HI    = 1200;
	localparam int SCRIPT_ROWS = 19;

	// address slot past the last register; writes there must be dropped
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

	typedef struct packed {
		logic [MOD_W-1:0]    coeff_lo;
		logic [MOD_W-1:0]    coeff_hi;
		logic [7:0]          position;
		logic                done;
		logic                accepted;
		logic [WEIGHT_W-1:0] weight;
	} pair_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [1:0]            idx;
		logic [APB_DATA_W-1:0] value;
		logic [7:0]            rbyte;
		logic                  known;
		pair_t                 want;
	} row_t;

	// Weight and position carry over from row to row, starting from reset.
	localparam row_t SCRIPT [SCRIPT_ROWS] = '{
		'{ROW_BYTE,  REG_MODULUS,    32'h0,         8'h00, 1'b1,
			'{8'd250, 8'd250, 8'd0, 1'b0, 1'b0, 10'd2}},
		'{ROW_BYTE,  REG_MODULUS,    32'h0,         8'hFF, 1'b1,
			'{8'd0, 8'd0, 8'd1, 1'b0, 1'b0, 10'd2}},
		'{ROW_BYTE,  REG_MODULUS,    32'h0,         8'h11, 1'b1,
			'{8'd1, 8'd1, 8'd2, 1'b0, 1'b0, 10'd4}},
		'{ROW_BYTE,  REG_MODULUS,    32'h0,         8'h98, 1'b1,
			'{8'd250, 8'd1, 8'd3, 1'b0, 1'b0, 10'd6}},
		'{ROW_BYTE,  REG_MODULUS,    32'h0,         8'hA7, 1'b1,
			'{8'd0, 8'd0, 8'd4, 1'b0, 1'b0, 10'd6}},
		'{ROW_BYTE,  REG_MODULUS,    32'h0,         8'h5E, 1'b0, '0},
		'{ROW_WRITE, REG_MODULUS,    32'hFFFF_FF00, 8'h00, 1'b0, '0},
		'{ROW_BYTE,  REG_MODULUS,    32'h0,         8'h80, 1'b1,
			'{8'd255, 8'd255, 8'd6, 1'b0, 1'b0, 10'd8}},
		'{ROW_WRITE, REG_MODULUS,    32'h0000_0001, 8'h00, 1'b0, '0},
		'{ROW_BYTE,  REG_MODULUS,    32'h0,         8'h08, 1'b1,
			'{8'd0, 8'd0, 8'd7, 1'b0, 1'b0, 10'd8}},
		'{ROW_WRITE, REG_MODULUS,    32'hABCD_00FF, 8'h00, 1'b0, '0},
		'{ROW_BYTE,  REG_MODULUS,    32'h0,         8'h01, 1'b1,
			'{8'd1, 8'd254, 8'd8, 1'b0, 1'b0, 10'd10}},
		'{ROW_WRITE, REG_MODULUS,    32'h0000_0002, 8'h00, 1'b0, '0},
		'{ROW_BYTE,  REG_MODULUS,    32'h0,         8'h10, 1'b1,
			'{8'd1, 8'd1, 8'd9, 1'b0, 1'b0, 10'd12}},
		'{ROW_WRITE, REG_SPARE,      32'hFFFF_FFFF, 8'h00, 1'b0, '0},
		'{ROW_BYTE,  REG_MODULUS,    32'h0,         8'h00, 1'b1,
			'{8'd1, 8'd1, 8'd10, 1'b0, 1'b0, 10'd14}},
		'{ROW_WRITE, REG_WEIGHT_MIN, 32'hFFFF_FFFF, 8'h00, 1'b0, '0},
		'{ROW_WRITE, REG_WEIGHT_MAX, 32'h0,         8'h00, 1'b0, '0},
		'{ROW_BYTE,  REG_MODULUS,    32'h0,         8'h69, 1'b0, '0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            random_byte = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [MOD_W-1:0]      coeff_first;
	logic [MOD_W-1:0]      coeff_second;
	logic [7:0]            pair_position;
	logic                  batch_done;
	logic                  batch_accepted;
	logic [WEIGHT_W-1:0]   batch_weight;

	// sampler model state and register copies
	logic [MOD_W-1:0]    mod_q = MODULUS_RST;
	logic [WEIGHT_W-1:0] wmin = WEIGHT_MIN_RST;
	logic [WEIGHT_W-1:0] wmax = WEIGHT_MAX_RST;
	int                  pairs_done = 0;
	int                  weight_run = 0;

	pair_t pending_pairs [$];

	int    bytes_sent = 0;
	int    results_seen = 0;
	int    batches_seen = 0;
	int    batches_kept = 0;
	int    mismatches = 0;
	int    cycle_count = 0;
	logic  hold_req = 1'b0;
	logic  hold_taken = 1'b0;
	int    hold_left = 0;

	sparse_ternary_weight_sampler #(.VECTOR_LENGTH(VEC_LEN)) u_top (.*);

	always #4 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic logic [MOD_W-1:0] ternary_of(input logic [3:0] nib);
		case (nib[2:0])
			3'd0: return mod_q - 8'd1;
			3'd1: return 8'd1;
			default: return 8'd0;
		endcase
	endfunction

	function automatic pair_t predict_pair(input logic [7:0] b);
		pair_t p;
		int    w;
		p.coeff_lo = ternary_of(b[3:0]);
		p.coeff_hi = ternary_of(b[7:4]);
		w = weight_run + (p.coeff_lo != 0) + (p.coeff_hi != 0);
		if (w > int'(WEIGHT_CAP))
			w = int'(WEIGHT_CAP);
		p.position = pairs_done[7:0];
		p.done = (pairs_done + 1 >= PAIRS);
		p.accepted = p.done && w >= wmin && w <= wmax;
		p.weight = w[WEIGHT_W-1:0];
		if (p.done) begin
			pairs_done = 0;
			weight_run = 0;
		end else begin
			pairs_done++;
			weight_run = w;
		end
		return p;
	endfunction

	// dense_pct: chance per nibble of a code that maps to a nonzero coefficient
	function automatic logic [7:0] draw_byte(input int dense_pct);
		logic [7:0] b;
		for (int k = 0; k < 2; k++) begin
			b[4*k+3] = 1'($urandom_range(1));
			if ($urandom_range(99) < dense_pct)
				b[4*k +: 3] = 3'($urandom_range(1));
			else
				b[4*k +: 3] = 3'($urandom_range(7, 2));
		end
		return b;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("mismatch at result %0d: %s got %0d, want %0d",
			results_seen, field, got, want);
		mismatches++;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic known, input pair_t want);
		pair_t p;
		if (bytes_sent < QUIET_LO || bytes_sent >= QUIET_HI)
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		random_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		p = predict_pair(b);
		pending_pairs.push_back(known ? want : p);
		bytes_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_pairs.size() != 0)
			@(posedge clk);
	endtask

	// registers change only with the pipeline empty
	task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
		logic [APB_DATA_W-1:0] rd_want;
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MODULUS:    mod_q = value[MOD_W-1:0];
			REG_WEIGHT_MIN: wmin = value[WEIGHT_W-1:0];
			REG_WEIGHT_MAX: wmax = value[WEIGHT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		// paddr still points at the register just written
		case (idx)
			REG_MODULUS:    rd_want = APB_DATA_W'(mod_q);
			REG_WEIGHT_MIN: rd_want = APB_DATA_W'(wmin);
			REG_WEIGHT_MAX: rd_want = APB_DATA_W'(wmax);
			default:        rd_want = '0;
		endcase
		if (prdata !== rd_want)
			report_mismatch("prdata", prdata, rd_want);
	endtask

	always @(posedge clk) begin
		pair_t got;
		pair_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {coeff_first, coeff_second, pair_position,
				batch_done, batch_accepted, batch_weight};
			if (pending_pairs.size() == 0) begin
				report_mismatch("unexpected transfer", 1, 0);
			end else begin
				want = pending_pairs.pop_front();
				if (got.coeff_lo !== want.coeff_lo)
					report_mismatch("coeff_first", got.coeff_lo, want.coeff_lo);
				if (got.coeff_hi !== want.coeff_hi)
					report_mismatch("coeff_second", got.coeff_hi, want.coeff_hi);
				if (got.position !== want.position)
					report_mismatch("pair_position", got.position, want.position);
				if (got.done !== want.done)
					report_mismatch("batch_done", got.done, want.done);
				if (got.accepted !== want.accepted)
					report_mismatch("batch_accepted", got.accepted, want.accepted);
				if (got.weight !== want.weight)
					report_mismatch("batch_weight", got.weight, want.weight);
				if (want.done) begin
					batches_seen++;
					if (want.accepted)
						batches_kept++;
				end
			end
			results_seen++;
		end
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		// hold the output long enough for the input side to back up
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (results_seen >= QUIET_LO && results_seen < QUIET_HI) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, pending_pairs.size());
		$display("sparse_ternary_weight_sampler regression: fail");
		$finish;
	end

	initial begin
		int                    phase;
		int                    pick;
		int                    dense;
		int                    span;
		logic [MOD_W-1:0]      m;
		logic [WEIGHT_W-1:0]   lo;
		logic [WEIGHT_W-1:0]   hi;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < SCRIPT_ROWS; r++) begin
			if (SCRIPT[r].kind == ROW_WRITE)
				write_reg(SCRIPT[r].idx, SCRIPT[r].value);
			else
				send_byte(SCRIPT[r].rbyte, SCRIPT[r].known, SCRIPT[r].want);
		end

		phase = 0;
		while (bytes_sent < BYTE_GOAL) begin
			pick = $urandom_range(5);
			case (pick)
				0: m = MODULUS_RST;
				1: m = 8'd0;
				2: m = 8'd1;
				3: m = 8'd2;
				4: m = 8'd255;
				default: m = 8'($urandom_range(255));
			endcase
			write_reg(REG_MODULUS, {24'($urandom), m});

			pick = $urandom_range(5);
			case (pick)
				0: begin lo = WEIGHT_MIN_RST; hi = WEIGHT_MAX_RST; end
				1: begin lo = 10'd0;          hi = 10'd1023;       end
				2: begin lo = WEIGHT_MAX_RST; hi = WEIGHT_MIN_RST; end
				3: begin lo = 10'd120;        hi = 10'd136;        end
				4: begin lo = 10'd128;        hi = 10'd128;        end
				default: begin
					lo = 10'($urandom_range(512));
					hi = 10'($urandom_range(512));
				end
			endcase
			write_reg(REG_WEIGHT_MIN, {22'($urandom), lo});
			write_reg(REG_WEIGHT_MAX, {22'($urandom), hi});
			if ($urandom_range(3) == 0)
				write_reg(REG_SPARE, $urandom);

			// bias the nonzero rate so vector weights straddle the bounds
			pick = $urandom_range(3);
			case (pick)
				0: dense = 25;
				1: dense = 20;
				2: dense = 30;
				default: dense = $urandom_range(100);
			endcase

			span = $urandom_range(320, 120);
			for (int n = 0; n < span && bytes_sent < BYTE_GOAL; n++) begin
				if (phase == 2 && n == 40)
					hold_req <= 1'b1;
				send_byte(draw_byte(dense), 1'b0, '0);
			end
			phase++;
		end

		wait_drained();
		repeat (6) @(posedge clk);

		$display("covered %0d byte transfers in %0d setting phases over %0d cycles",
			bytes_sent, phase, cycle_count);
		$display("%0d vectors completed, %0d within bounds, %0d mismatches",
			batches_seen, batches_kept, mismatches);
		if (mismatches == 0)
			$display("sparse_ternary_weight_sampler regression: pass");
		else
			$display("sparse_ternary_weight_sampler regression: fail");
		$finish;
	end

endmodule
